FILE: design/lgl_pkg.sv
// Package: shared types, constants and table builders for the gamma and levels block.
package lgl_pkg;

	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic        last_pixel;
	} lgl_in_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic        last_out;
	} lgl_out_t;

	typedef enum logic [2:0] {
		CFG_IN_LOW    = 3'd0,
		CFG_WHITE_IN  = 3'd1,
		CFG_OUT_LOW   = 3'd2,
		CFG_WHITE_OUT = 3'd3,
		CFG_GAMMA     = 3'd4
	} cfg_reg_e;

	typedef enum logic [2:0] {
		GM_UNITY,
		GM_MAX,
		GM_ZERO,
		GM_LEFT,
		GM_RIGHT
	} gain_mode_t;

	localparam logic [15:0] W_RED    = 16'd13933;
	localparam logic [15:0] W_GREEN  = 16'd46871;
	localparam logic [15:0] W_BLUE   = 16'd4732;
	localparam logic [15:0] GAMMA_ONE = 16'd4096;
	localparam int          SHIFT_BITS = 5;
	localparam int          GAIN_LAT = 8;
	localparam int          LVL_FIXED_LAT = 8;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = x;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2(1 + i/2^a) in Q16 by repeated squaring
	function automatic logic [16:0] log_entry(input int a, input int i);
		logic [63:0] y;
		logic [63:0] r;
		y = 64'((1 << a) + i) << (30 - a);
		r = 64'd0;
		for (int b = 0; b < 20; b++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= (64'd2 << 30)) begin
				r = r | 64'd1;
				y = y >> 1;
			end
		end
		return 17'((r + 64'd8) >> 4);
	endfunction

	// 2^(i/2^a) in Q16 as a product of square roots of two
	function automatic logic [16:0] exp_entry(input int a, input int i);
		logic [63:0] root [13];
		logic [63:0] p;
		for (int k = 0; k < 13; k++)
			root[k] = 64'd0;
		root[0] = 64'd2 << 30;
		for (int k = 1; k <= a; k++)
			root[k] = isqrt64(root[k - 1] << 30);
		p = 64'd1 << 30;
		for (int b = 0; b < a; b++)
			if (((i >> b) & 1) != 0)
				p = (p * root[a - b] + (64'd1 << 29)) >> 30;
		return 17'((p + 64'd8192) >> 14);
	endfunction

endpackage

FILE: design/luminance_gamma_levels_top.sv
// Top level: gamma and levels adjustment of an RGB pixel stream, one pixel per clock.
// Each pixel is scaled by (L)^(gamma-1), L its Rec.709 luminance, after input levels
// remapping, then placed on the output levels and clamped. One pixel is accepted per clock
// while the output is taken. Each result passes through the gain pipeline (8 stages) and
// then the per-channel levels pipeline, whose restoring divider resolves one quotient
// bit per stage.
// pix_ready drops only while a result waits at the output. Configuration is taken at any
// time and must be written while no pixel is in flight.
module luminance_gamma_levels_top #(
	parameter int PIXEL_BITS      = 16,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  lgl_pkg::lgl_in_t pix,
	output logic             res_valid,
	input  logic             res_ready,
	output lgl_pkg::lgl_out_t res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_addr,
	input  logic [15:0]      cfg_wdata
);
	import lgl_pkg::*;

	localparam int P   = PIXEL_BITS;
	localparam int LAT = GAIN_LAT + LVL_FIXED_LAT + P + 17;

	logic [P-1:0] in_low_q, white_in_q, out_low_q, white_out_q;
	logic [15:0]  gamma_q;

	logic         en;
	logic         vld_s [LAT+1];
	logic         last_s [LAT+1];
	logic [P-1:0] red_s [GAIN_LAT+1];
	logic [P-1:0] grn_s [GAIN_LAT+1];
	logic [P-1:0] blu_s [GAIN_LAT+1];

	logic [P:0]    s_c, o_c;
	logic [P-1:0]  sm0_c, span_c, om_c;
	logic          flip_c;
	logic [P+15:0] gain;
	logic [P-1:0]  lvl_r, lvl_g, lvl_b;

	assign cfg_ready = 1'b1;
	assign en        = !vld_s[LAT] || res_ready;
	assign pix_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q    <= '0;
			white_in_q  <= '1;
			out_low_q   <= '0;
			white_out_q <= '1;
			gamma_q     <= GAMMA_ONE;
		end else if (cfg_valid) begin
			case (cfg_reg_e'(cfg_addr))
				CFG_IN_LOW:    in_low_q    <= P'(cfg_wdata);
				CFG_WHITE_IN:  white_in_q  <= P'(cfg_wdata);
				CFG_OUT_LOW:   out_low_q   <= P'(cfg_wdata);
				CFG_WHITE_OUT: white_out_q <= P'(cfg_wdata);
				CFG_GAMMA:     gamma_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_c    = {1'b0, white_in_q} - {1'b0, in_low_q};
	assign o_c    = {1'b0, white_out_q} - {1'b0, out_low_q};
	assign sm0_c  = s_c[P] ? P'(-s_c) : s_c[P-1:0];
	assign span_c = (sm0_c == '0) ? P'(1) : sm0_c;
	assign om_c   = o_c[P] ? P'(-o_c) : o_c[P-1:0];
	assign flip_c = s_c[P] ^ o_c[P];

	assign vld_s[0]  = pix_valid;
	assign last_s[0] = pix.last_pixel;
	assign red_s[0]  = P'(pix.red_in);
	assign grn_s[0]  = P'(pix.green_in);
	assign blu_s[0]  = P'(pix.blue_in);

	for (genvar k = 1; k <= LAT; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en)
				last_s[k] <= last_s[k-1];
		end
	end

	for (genvar k = 1; k <= GAIN_LAT; k++) begin : g_chan
		always_ff @(posedge clk) begin
			if (en) begin
				red_s[k] <= red_s[k-1];
				grn_s[k] <= grn_s[k-1];
				blu_s[k] <= blu_s[k-1];
			end
		end
	end

	lgl_gain #(.P(P), .A(TABLE_ADDR_BITS)) u_gain (
		.clk   (clk),
		.en    (en),
		.red   (red_s[0]),
		.green (grn_s[0]),
		.blue  (blu_s[0]),
		.gamma (gamma_q),
		.gain  (gain)
	);

	lgl_level #(.P(P)) u_lvl_r (
		.clk(clk), .en(en), .chan(red_s[GAIN_LAT]), .gain(gain), .in_low(in_low_q),
		.span(span_c), .range_mag(om_c), .out_low(out_low_q), .flip(flip_c),
		.level(lvl_r)
	);

	lgl_level #(.P(P)) u_lvl_g (
		.clk(clk), .en(en), .chan(grn_s[GAIN_LAT]), .gain(gain), .in_low(in_low_q),
		.span(span_c), .range_mag(om_c), .out_low(out_low_q), .flip(flip_c),
		.level(lvl_g)
	);

	lgl_level #(.P(P)) u_lvl_b (
		.clk(clk), .en(en), .chan(blu_s[GAIN_LAT]), .gain(gain), .in_low(in_low_q),
		.span(span_c), .range_mag(om_c), .out_low(out_low_q), .flip(flip_c),
		.level(lvl_b)
	);

	assign res_valid     = vld_s[LAT];
	assign res.red_out   = 16'(lvl_r);
	assign res.green_out = 16'(lvl_g);
	assign res.blue_out  = 16'(lvl_b);
	assign res.last_out  = last_s[LAT];

endmodule

FILE: design/lgl_gain.sv
// Gain factor pipeline: luminance, log2 lookup, gamma scaling, exp2 lookup.
module lgl_gain #(
	parameter int P = 16,
	parameter int A = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic [P-1:0]  red,
	input  logic [P-1:0]  green,
	input  logic [P-1:0]  blue,
	input  logic [15:0]   gamma,
	output logic [P+15:0] gain
);
	import lgl_pkg::*;

	localparam int TSIZE = 1 << A;
	localparam int EW    = $clog2(P);
	localparam int ULW   = $clog2(P + 1) + 17;
	localparam int MW    = ULW + 5;
	localparam int NWD   = MW - 16;
	localparam int CW    = P + 16;

	typedef logic [16:0] rom_t [TSIZE];

	function automatic rom_t make_log();
		rom_t t;
		for (int i = 0; i < TSIZE; i++)
			t[i] = log_entry(A, i);
		return t;
	endfunction

	function automatic rom_t make_exp();
		rom_t t;
		for (int i = 0; i < TSIZE; i++)
			t[i] = exp_entry(A, i);
		return t;
	endfunction

	localparam rom_t LOG_TAB = make_log();
	localparam rom_t EXP_TAB = make_exp();

	logic [P+15:0]   pr_s1, pg_s1, pb_s1;
	logic [P-1:0]    lum_s2;
	logic [EW-1:0]   e_s3, e_s4;
	logic [A-1:0]    idx_s3;
	logic            lz_s3, lz_s4, lz_s5, lz_s6;
	logic [16:0]     log_s4;
	logic [ULW-1:0]  ulg_s5;
	logic [MW-1:0]   mag_s6;
	gain_mode_t      mode_s7;
	logic [SHIFT_BITS-1:0] sh_s7;
	logic [16:0]     exp_s7;
	logic [CW-1:0]   gain_s8;

	logic [P+17:0]   lsum;
	logic [EW-1:0]   e_c;
	logic [P+A-1:0]  norm;
	logic            g_neg, g_unity;
	logic [15:0]     g_mag;
	logic [ULW+16:0] mprod;
	logic [NWD-1:0]  n_c;
	logic [15:0]     f_c, f2_c;
	logic [NWD:0]    n2_c;
	logic [A-1:0]    eidx_c;
	gain_mode_t      mode_c;
	logic [SHIFT_BITS-1:0] sh_c;
	logic [P+16:0]   lwide;
	logic [CW-1:0]   gain_c;

	assign g_neg   = gamma < GAMMA_ONE;
	assign g_unity = gamma == GAMMA_ONE;
	assign g_mag   = g_neg ? GAMMA_ONE - gamma : gamma - GAMMA_ONE;

	assign lsum = (P+18)'(pr_s1) + (P+18)'(pg_s1) + (P+18)'(pb_s1) + (P+18)'(32768);

	always_comb begin
		e_c = '0;
		for (int j = 0; j < P; j++)
			if (lum_s2[j])
				e_c = EW'(j);
	end

	assign norm  = {lum_s2, A'(0)} >> e_c;
	assign mprod = (ULW+17)'(ulg_s5) * (ULW+17)'(g_mag) + (ULW+17)'(2048);

	assign n_c  = mag_s6[MW-1:16];
	assign f_c  = mag_s6[15:0];
	assign n2_c = (NWD+1)'(n_c) + (NWD+1)'(f_c != 16'd0);
	assign f2_c = (f_c != 16'd0) ? 16'(17'h10000 - 17'(f_c)) : 16'd0;

	always_comb begin
		mode_c = GM_RIGHT;
		sh_c   = '0;
		eidx_c = f2_c[15 -: A];
		if (g_unity) begin
			mode_c = GM_UNITY;
		end else if (lz_s6) begin
			mode_c = g_neg ? GM_MAX : GM_ZERO;
		end else if (g_neg) begin
			eidx_c = f_c[15 -: A];
			if (n_c > NWD'(P)) begin
				mode_c = GM_MAX;
			end else begin
				mode_c = GM_LEFT;
				sh_c   = SHIFT_BITS'(n_c);
			end
		end else begin
			mode_c = GM_RIGHT;
			sh_c   = (n2_c > (NWD+1)'(31)) ? SHIFT_BITS'(31) : SHIFT_BITS'(n2_c);
		end
	end

	assign lwide = (P+17)'(exp_s7) << sh_s7;

	always_comb begin
		case (mode_s7)
			GM_UNITY: gain_c = CW'(65536);
			GM_MAX:   gain_c = '1;
			GM_ZERO:  gain_c = '0;
			GM_LEFT:  gain_c = lwide[P+16] ? '1 : lwide[CW-1:0];
			GM_RIGHT: gain_c = CW'(exp_s7 >> sh_s7);
			default:  gain_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1   <= (P+16)'(red) * (P+16)'(W_RED);
			pg_s1   <= (P+16)'(green) * (P+16)'(W_GREEN);
			pb_s1   <= (P+16)'(blue) * (P+16)'(W_BLUE);
			lum_s2  <= lsum[P+15:16];
			e_s3    <= e_c;
			idx_s3  <= norm[A-1:0];
			lz_s3   <= lum_s2 == '0;
			log_s4  <= LOG_TAB[idx_s3];
			e_s4    <= e_s3;
			lz_s4   <= lz_s3;
			ulg_s5  <= ULW'(P << 16) - (ULW'(e_s4) << 16) - ULW'(log_s4);
			lz_s5   <= lz_s4;
			mag_s6  <= mprod[ULW+16:12];
			lz_s6   <= lz_s5;
			mode_s7 <= mode_c;
			sh_s7   <= sh_c;
			exp_s7  <= EXP_TAB[eidx_c];
			gain_s8 <= gain_c;
		end
	end

	assign gain = gain_s8;

endmodule

FILE: design/lgl_level.sv
// Per-channel levels mapping: subtract input low, scale by gain, divide by input span, map to output range, clamp.
module lgl_level #(
	parameter int P = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [P-1:0]  chan,
	input  logic [P+15:0] gain,
	input  logic [P-1:0]  in_low,
	input  logic [P-1:0]  span,
	input  logic [P-1:0]  range_mag,
	input  logic [P-1:0]  out_low,
	input  logic          flip,
	output logic [P-1:0]  level
);
	localparam int QB = P + 17;
	localparam int NW = 2 * P + 16;
	localparam int OW = 2 * P + 4;

	logic [P-1:0]    dm_s1;
	logic            neg_s1, neg_s2, neg_s3;
	logic [P+15:0]   gain_s1;
	logic [P+15:0]   pl_s2;
	logic [2*P-1:0]  ph_s2;
	logic [NW-1:0]   num_s3;
	logic [P-1:0]    dv_rem_s [QB+1];
	logic [QB-1:0]   dv_low_s [QB+1];
	logic [QB-1:0]   dv_quo_s [QB+1];
	logic            dv_ovf_s [QB+1];
	logic            dv_neg_s [QB+1];
	logic [QB-1:0]   x_s5;
	logic            neg_s5, neg_s6, neg_s7;
	logic [P+15:0]   ml_s6;
	logic [2*P:0]    mh_s6;
	logic [2*P+1:0]  m_s7;
	logic [P-1:0]    level_s8;

	logic [P:0]      d_c;
	logic [NW:0]     nsum;
	logic [2*P+17:0] msum;
	logic [OW-1:0]   v_c;

	assign d_c  = {1'b0, chan} - {1'b0, in_low};
	assign nsum = (NW+1)'({ph_s2, 16'h0}) + (NW+1)'(pl_s2) + (NW+1)'(span >> 1);
	assign msum = (2*P+18)'({mh_s6, 16'h0}) + (2*P+18)'(ml_s6) + (2*P+18)'(32768);
	assign v_c  = neg_s7 ? OW'(out_low) - OW'(m_s7) : OW'(out_low) + OW'(m_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s1       <= d_c[P] ? P'(-d_c) : d_c[P-1:0];
			neg_s1      <= d_c[P] ^ flip;
			gain_s1     <= gain;
			pl_s2       <= (P+16)'(dm_s1) * (P+16)'(gain_s1[15:0]);
			ph_s2       <= (2*P)'(dm_s1) * (2*P)'(gain_s1[P+15:16]);
			neg_s2      <= neg_s1;
			num_s3      <= nsum[NW-1:0];
			neg_s3      <= neg_s2;
			dv_rem_s[0] <= P'(num_s3[NW-1:QB]);
			dv_low_s[0] <= num_s3[QB-1:0];
			dv_quo_s[0] <= '0;
			dv_ovf_s[0] <= P'(num_s3[NW-1:QB]) >= span;
			dv_neg_s[0] <= neg_s3;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [P:0] t;
		logic       ge;
		assign t  = {dv_rem_s[k], dv_low_s[k][QB-1]};
		assign ge = t >= {1'b0, span};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k+1] <= ge ? P'(t - {1'b0, span}) : t[P-1:0];
				dv_low_s[k+1] <= dv_low_s[k] << 1;
				dv_quo_s[k+1] <= {dv_quo_s[k][QB-2:0], ge};
				dv_ovf_s[k+1] <= dv_ovf_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_ovf_s[QB] || dv_quo_s[QB] > (QB'(1) << (P + 16)))
				x_s5 <= QB'(1) << (P + 16);
			else
				x_s5 <= dv_quo_s[QB];
			neg_s5   <= dv_neg_s[QB];
			ml_s6    <= (P+16)'(x_s5[15:0]) * (P+16)'(range_mag);
			mh_s6    <= (2*P+1)'(x_s5[QB-1:16]) * (2*P+1)'(range_mag);
			neg_s6   <= neg_s5;
			m_s7     <= msum[2*P+17:16];
			neg_s7   <= neg_s6;
			if (v_c[OW-1])
				level_s8 <= '0;
			else if (|v_c[OW-2:P])
				level_s8 <= '1;
			else
				level_s8 <= v_c[P-1:0];
		end
	end

	assign level = level_s8;

endmodule

FILE: design/lgl_checker.sv
// Port-level checker for the gamma and levels block, bound to the top level.
module lgl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_ready,
	input logic              res_valid,
	input logic              res_ready,
	input lgl_pkg::lgl_out_t res
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input stalled with empty output");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> pix_ready)
		else $error("input stalled while output drains");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pix_ready)
		else $error("item taken while output stalled");

endmodule

bind luminance_gamma_levels_top lgl_checker u_chk (.*);
